>>> rtl/poa_pkg.sv
// shared types, widths and codes for the planar odometry accumulator
`default_nettype none
package poa_pkg;

  localparam int PosW     = 32;              // signed q24.8 coordinate
  localparam int DiffW    = PosW + 1;        // exact coordinate difference
  localparam int MagW     = PosW;            // |difference| < 2^32
  localparam int ScaleW   = 16;              // unsigned q8.8 scale
  localparam int TotalW   = 48;              // unsigned q40.8 total
  localparam int CountW   = 32;
  localparam int FracW    = 8;
  localparam int ReqW     = 2;

  localparam int RadW     = 2 * MagW + 1;    // dx^2 + dy^2
  localparam int RadPadW  = RadW + 1;        // even width for digit pairs
  localparam int RootW    = RadPadW / 2;     // one root bit per digit pair
  localparam int RemW     = RootW + 1;       // remainder stays below 2*root+1
  localparam int SqrtSteps = RootW;
  localparam int SqrtCntW = $clog2(SqrtSteps);

  localparam int MulAW    = RootW;
  localparam int MulBW    = MagW;
  localparam int ProdW    = 2 * MagW;
  localparam int IncW     = TotalW + 1;

  localparam logic [ScaleW-1:0]   ScaleReset = ScaleW'(256);
  localparam logic [TotalW-1:0]   TotalMax   = {TotalW{1'b1}};
  localparam logic [CountW-1:0]   CountMax   = {CountW{1'b1}};
  localparam logic [SqrtCntW-1:0] SqrtLast   = SqrtCntW'(SqrtSteps - 1);

  // request codes carried in tuser
  localparam logic [ReqW-1:0] REQ_X    = 2'd0;
  localparam logic [ReqW-1:0] REQ_Y    = 2'd1;
  localparam logic [ReqW-1:0] REQ_EVAL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ADD,
    ST_ROOT,
    ST_SCALE,
    ST_ACC,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage
`default_nettype wire

>>> rtl/poa_isqrt.sv
// iterative integer square root, one result bit per cycle
`default_nettype none
module poa_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [poa_pkg::RadW-1:0]      radicand,
  output poa_pkg::sqrt_stat_t           stat,
  output logic [poa_pkg::RootW-1:0]     root
);

  logic                             busy;
  logic [poa_pkg::SqrtCntW-1:0]     cnt;
  logic [poa_pkg::RadPadW-1:0]      rad_sh;
  logic [poa_pkg::RemW-1:0]         rem;
  logic [poa_pkg::RemW+1:0]         rem_sh;
  logic [poa_pkg::RemW+1:0]         trial;
  logic [poa_pkg::RemW+1:0]         rem_sub;
  logic                             fits;

  // bring down the next digit pair and try root*4+1
  assign rem_sh  = {rem, rad_sh[poa_pkg::RadPadW-1 -: 2]};
  assign trial   = (poa_pkg::RemW + 2)'({root, 2'b01});
  assign rem_sub = rem_sh - trial;
  assign fits    = rem_sh >= trial;

  assign stat.busy = busy;
  assign stat.done = busy && (cnt == poa_pkg::SqrtLast);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == poa_pkg::SqrtLast) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= poa_pkg::RadPadW'(radicand);
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[poa_pkg::RadPadW-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_sub[poa_pkg::RemW-1:0];
        root <= {root[poa_pkg::RootW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[poa_pkg::RemW-1:0];
        root <= {root[poa_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  // a new root must never be started over one in flight
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("square root restarted while busy");

endmodule
`default_nettype wire

>>> rtl/planar_odometry_accumulator_unit.sv
// top level of the planar odometry accumulator: sequencer, shared multiplier, state
`default_nettype none
// Tracks a planar position from x and y update words and, on each evaluate word,
// adds the scaled straight-line step length floor(sqrt(dx^2+dy^2)) * scale / 256 to a
// saturating 48-bit q40.8 total and counts the step (saturating at 2^32-1). The first
// update that moves away from the origin seeds the previous point; evaluates before
// that, or without movement, change nothing. Every input word yields exactly one
// output word carrying the total, the count and a step flag. The unit handles one
// word at a time; an evaluate with movement also runs the bit-serial square root of
// the 65-bit radicand. The two squares and the scaling all run through one 33x32
// multiplier in turn. Output backpressure adds cycles only while the previous
// result is still held in the output register. distance_scale is written through
// cfg_we/cfg_wdata; the user must write it only while the unit is idle, which the
// unit itself does not enforce; it resets to 256 (1.0).
module planar_odometry_accumulator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // position_value[31:0]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // total_distance[47:0], sample_count[79:48]
  output logic        m_axis_tuser,   // step_taken[0]
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata       // distance_scale[15:0]
);

  poa_pkg::state_t state, state_next;

  // architectural state
  logic [poa_pkg::PosW-1:0]   current_x, current_y, previous_x, previous_y;
  logic                       seeded;
  logic [poa_pkg::TotalW-1:0] total;
  logic [poa_pkg::CountW-1:0] count;
  logic [poa_pkg::ScaleW-1:0] scale;

  // working registers
  logic [poa_pkg::MagW-1:0]   mag_x, mag_y;
  logic [poa_pkg::ProdW-1:0]  prod;
  logic [poa_pkg::ProdW-1:0]  sq_x;
  logic                       taken;

  // output register
  logic                       out_valid;
  logic [poa_pkg::TotalW-1:0] out_total;
  logic [poa_pkg::CountW-1:0] out_count;
  logic                       out_taken;

  // combinational
  logic                             in_fire;
  logic                             is_update;
  logic [poa_pkg::PosW-1:0]         cx_new, cy_new;
  logic                             moved;
  logic [poa_pkg::DiffW-1:0]        dx, dy, dx_neg, dy_neg;
  logic [poa_pkg::MulAW-1:0]        mul_a;
  logic [poa_pkg::MulBW-1:0]        mul_b;
  logic [poa_pkg::MulAW+poa_pkg::MulBW-1:0] mul_p;
  logic [poa_pkg::RadW-1:0]         rad_sum;
  logic [poa_pkg::IncW-1:0]         sum_wide;
  logic [poa_pkg::TotalW-1:0]       total_sat;
  logic [poa_pkg::CountW-1:0]       count_sat;
  logic                             out_free;
  logic                             load_out;
  logic                             sq_start;
  poa_pkg::sqrt_stat_t              sq_stat;
  logic [poa_pkg::RootW-1:0]        root;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign is_update = (s_axis_tuser == poa_pkg::REQ_X) || (s_axis_tuser == poa_pkg::REQ_Y);
  assign cx_new    = (s_axis_tuser == poa_pkg::REQ_X) ? s_axis_tdata : current_x;
  assign cy_new    = (s_axis_tuser == poa_pkg::REQ_Y) ? s_axis_tdata : current_y;
  assign moved     = (current_x != previous_x) || (current_y != previous_y);

  // exact signed differences, then magnitudes (always below 2^32)
  assign dx     = {current_x[poa_pkg::PosW-1], current_x} - {previous_x[poa_pkg::PosW-1], previous_x};
  assign dy     = {current_y[poa_pkg::PosW-1], current_y} - {previous_y[poa_pkg::PosW-1], previous_y};
  assign dx_neg = ~dx + poa_pkg::DiffW'(1);
  assign dy_neg = ~dy + poa_pkg::DiffW'(1);

  // the one shared multiplier
  assign mul_p = mul_a * mul_b;

  // radicand dx^2 + dy^2, handed to the root unit on start
  assign rad_sum = {1'b0, sq_x} + {1'b0, prod};

  // increment = floor(root * scale / 256), below 2^41; saturate the total
  assign sum_wide  = {1'b0, total}
                   + prod[poa_pkg::IncW+poa_pkg::FracW-1:poa_pkg::FracW];
  assign total_sat = (sum_wide >= {1'b0, poa_pkg::TotalMax}) ? poa_pkg::TotalMax
                                                             : sum_wide[poa_pkg::TotalW-1:0];
  assign count_sat = (count == poa_pkg::CountMax) ? count : count + 1'b1;

  assign out_free = !out_valid || m_axis_tready;

  poa_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (rad_sum),
    .stat     (sq_stat),
    .root     (root)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      poa_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = (s_axis_tuser == poa_pkg::REQ_EVAL) ? poa_pkg::ST_DIFF
                                                           : poa_pkg::ST_RESULT;
        end
      end
      poa_pkg::ST_DIFF:   state_next = (seeded && moved) ? poa_pkg::ST_SQ_X : poa_pkg::ST_RESULT;
      poa_pkg::ST_SQ_X:   state_next = poa_pkg::ST_SQ_Y;
      poa_pkg::ST_SQ_Y:   state_next = poa_pkg::ST_ADD;
      poa_pkg::ST_ADD:    state_next = poa_pkg::ST_ROOT;
      poa_pkg::ST_ROOT:   state_next = sq_stat.done ? poa_pkg::ST_SCALE : poa_pkg::ST_ROOT;
      poa_pkg::ST_SCALE:  state_next = poa_pkg::ST_ACC;
      poa_pkg::ST_ACC:    state_next = poa_pkg::ST_RESULT;
      poa_pkg::ST_RESULT: state_next = out_free ? poa_pkg::ST_IDLE : poa_pkg::ST_RESULT;
      default:            state_next = poa_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    sq_start      = 1'b0;
    load_out      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state)
      poa_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      poa_pkg::ST_SQ_X: begin
        mul_a = poa_pkg::MulAW'(mag_x);
        mul_b = mag_x;
      end
      poa_pkg::ST_SQ_Y: begin
        mul_a = poa_pkg::MulAW'(mag_y);
        mul_b = mag_y;
      end
      poa_pkg::ST_ADD:    sq_start = 1'b1;
      poa_pkg::ST_SCALE: begin
        mul_a = root;
        mul_b = poa_pkg::MulBW'(scale);
      end
      poa_pkg::ST_RESULT: load_out = out_free;
      default: begin
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= poa_pkg::ST_IDLE;
      current_x  <= '0;
      current_y  <= '0;
      previous_x <= '0;
      previous_y <= '0;
      seeded     <= 1'b0;
      total      <= '0;
      count      <= '0;
      scale      <= poa_pkg::ScaleReset;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        scale <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      // position updates land straight away; first move off the origin seeds
      if (state == poa_pkg::ST_IDLE && in_fire && is_update) begin
        current_x <= cx_new;
        current_y <= cy_new;
        if (!seeded && (cx_new != previous_x || cy_new != previous_y)) begin
          previous_x <= cx_new;
          previous_y <= cy_new;
          seeded     <= 1'b1;
        end
      end
      if (state == poa_pkg::ST_ACC) begin
        total      <= total_sat;
        count      <= count_sat;
        previous_x <= current_x;
        previous_y <= current_y;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    unique case (state)
      poa_pkg::ST_IDLE: begin
        if (in_fire) begin
          taken <= 1'b0;
        end
      end
      poa_pkg::ST_DIFF: begin
        mag_x <= dx[poa_pkg::DiffW-1] ? dx_neg[poa_pkg::MagW-1:0] : dx[poa_pkg::MagW-1:0];
        mag_y <= dy[poa_pkg::DiffW-1] ? dy_neg[poa_pkg::MagW-1:0] : dy[poa_pkg::MagW-1:0];
      end
      poa_pkg::ST_SQ_X:  prod <= mul_p[poa_pkg::ProdW-1:0];
      poa_pkg::ST_SQ_Y: begin
        sq_x <= prod;
        prod <= mul_p[poa_pkg::ProdW-1:0];
      end
      poa_pkg::ST_SCALE: prod <= mul_p[poa_pkg::ProdW-1:0];
      poa_pkg::ST_ACC:   taken <= 1'b1;
      poa_pkg::ST_RESULT: begin
        if (load_out) begin
          out_total <= total;
          out_count <= count;
          out_taken <= taken;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_count, out_total};
  assign m_axis_tuser  = out_taken;

  // the running total only ever grows
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> total >= $past(total))
    else $error("distance total decreased");

  // a word reporting a step always carries a nonzero count
  a_step_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_taken) |-> (out_count != '0))
    else $error("step reported with zero count");

  // the root unit is quiet whenever the sequencer waits for input
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == poa_pkg::ST_IDLE) |-> !sq_stat.busy)
    else $error("square root busy while idle");

endmodule
`default_nettype wire
